[rtl/sha1s_pkg.sv]
// Shared types and constants for the SHA-1 streaming hash engine.
package sha1s_pkg;

    localparam int WordW    = 32;
    localparam int WinDepth = 16;
    localparam int WinAw    = $clog2(WinDepth);
    localparam int Rounds   = 80;
    localparam int RndW     = $clog2(Rounds);
    localparam int CountW   = 61;
    localparam int NumWords = 5;
    localparam int IdxW     = 3;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [WordW-1:0] K0 = 32'h5A827999;
    localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

    localparam logic [WordW-1:0] IV0 = 32'h67452301;
    localparam logic [WordW-1:0] IV1 = 32'hEFCDAB89;
    localparam logic [WordW-1:0] IV2 = 32'h98BADCFE;
    localparam logic [WordW-1:0] IV3 = 32'h10325476;
    localparam logic [WordW-1:0] IV4 = 32'hC3D2E1F0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_FILL,
        ST_PRIME,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic iv;    // restore chaining value to IV
        logic load;  // copy chaining value into working registers
        logic step;  // run one round
        logic add;   // fold working registers into chaining value
    } core_ctrl_t;

endpackage

[rtl/sha1s_wram.sv]
// 16 x 32 word RAM, one write port, two registered read ports.
module sha1s_wram (
    input  logic                              clk,
    input  logic                              we,
    input  logic [sha1s_pkg::WinAw-1:0]       waddr,
    input  logic [sha1s_pkg::WordW-1:0]       wdata,
    input  logic [sha1s_pkg::WinAw-1:0]       raddr0,
    input  logic [sha1s_pkg::WinAw-1:0]       raddr1,
    output logic [sha1s_pkg::WordW-1:0]       rdata0,
    output logic [sha1s_pkg::WordW-1:0]       rdata1
);

    logic [sha1s_pkg::WordW-1:0] mem [sha1s_pkg::WinDepth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

[rtl/sha1s_core.sv]
// SHA-1 round datapath: working registers, schedule expansion, chaining value.
module sha1s_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sha1s_pkg::core_ctrl_t             ctrl,
    input  logic [sha1s_pkg::RndW-1:0]        rnd,
    input  logic [sha1s_pkg::WordW-1:0]       w3,
    input  logic [sha1s_pkg::WordW-1:0]       w8,
    input  logic [sha1s_pkg::WordW-1:0]       w14,
    input  logic [sha1s_pkg::WordW-1:0]       w16,
    input  logic [sha1s_pkg::IdxW-1:0]        word_sel,
    output logic [sha1s_pkg::WordW-1:0]       w,
    output logic [sha1s_pkg::WordW-1:0]       chain_word
);

    localparam int W = sha1s_pkg::WordW;

    logic [W-1:0] chain_reg [sha1s_pkg::NumWords];
    logic [W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [W-1:0] x, f, k, t;

    // first 16 rounds take the message word straight from the window
    always_comb
    begin
        x = w3 ^ w8 ^ w14 ^ w16;
        if (rnd < sha1s_pkg::RndW'(16))
        begin
            w = w16;
        end
        else
        begin
            w = {x[W-2:0], x[W-1]};
        end
    end

    always_comb
    begin
        priority if (rnd < sha1s_pkg::RndW'(20))
        begin
            f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k = sha1s_pkg::K0;
        end
        else if (rnd < sha1s_pkg::RndW'(40))
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1s_pkg::K1;
        end
        else if (rnd < sha1s_pkg::RndW'(60))
        begin
            f = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k = sha1s_pkg::K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1s_pkg::K3;
        end
        t = {a_reg[W-6:0], a_reg[W-1:W-5]} + f + e_reg + k + w;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (ctrl.step)
        begin
            a_reg <= t;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[W-1:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= sha1s_pkg::IV0;
            chain_reg[1] <= sha1s_pkg::IV1;
            chain_reg[2] <= sha1s_pkg::IV2;
            chain_reg[3] <= sha1s_pkg::IV3;
            chain_reg[4] <= sha1s_pkg::IV4;
        end
        else if (ctrl.iv)
        begin
            chain_reg[0] <= sha1s_pkg::IV0;
            chain_reg[1] <= sha1s_pkg::IV1;
            chain_reg[2] <= sha1s_pkg::IV2;
            chain_reg[3] <= sha1s_pkg::IV3;
            chain_reg[4] <= sha1s_pkg::IV4;
        end
        else if (ctrl.add)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    always_comb
    begin
        if (word_sel < sha1s_pkg::IdxW'(sha1s_pkg::NumWords))
        begin
            chain_word = chain_reg[word_sel];
        end
        else
        begin
            chain_word = '0;
        end
    end

endmodule

[rtl/sha1_stream_hash.sv]
// SHA-1 streaming hash engine top level: sequencer, block fill, padding, digest output.
//
//  channel  | valid / ready               | payload
//  ---------+-----------------------------+-----------------------------------
//  command  | cmd_valid / cmd_ready       | command, data_byte
//  digest   | digest_valid / digest_ready | digest_word, word_index, last_word
//
//  The beat that completes a 64-byte block is followed by a busy compression
//  (prime, 80 rounds, chain add), run at one round per cycle on the duplicated
//  schedule RAM.
//  Finish: 1 pad write, up to 15 fill writes, one compression per block
//  (two blocks when 56 or more bytes are buffered, the second one after 16
//  more fill writes), then five digest beats.
//  Reset loads the initial chaining value and a zero count; the RAMs are not
//  cleared. Input is held off while compressing or emitting the digest.
module sha1_stream_hash (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic                              command,
    input  logic [7:0]                        data_byte,
    output logic                              digest_valid,
    input  logic                              digest_ready,
    output logic [sha1s_pkg::WordW-1:0]       digest_word,
    output logic [sha1s_pkg::IdxW-1:0]        word_index,
    output logic                              last_word
);

    localparam int W  = sha1s_pkg::WordW;
    localparam int AW = sha1s_pkg::WinAw;

    sha1s_pkg::state_t          state_reg, state_next;
    logic [sha1s_pkg::CountW-1:0] count_reg, count_next;
    logic [W-1:0]               acc_reg, acc_next;
    logic [AW-1:0]              pidx_reg, pidx_next;
    logic [sha1s_pkg::RndW-1:0] rnd_reg, rnd_next;
    logic [sha1s_pkg::IdxW-1:0] idx_reg, idx_next;
    logic                       fin_reg, fin_next;
    logic                       long_reg, long_next;

    sha1s_pkg::core_ctrl_t      ctrl;
    logic                       we;
    logic [AW-1:0]              waddr, base;
    logic [W-1:0]               wdata, merged, pad_word, core_w;
    logic [W-1:0]               rd3, rd8, rd14, rd16;
    logic [63:0]                bit_len;
    logic [5:0]                 fill;
    logic [AW-1:0]              widx;
    logic [1:0]                 bsel;

    function automatic logic [W-1:0] byte_merge(input logic [W-1:0] acc,
                                                input logic [7:0]   b,
                                                input logic [1:0]   sel);
        logic [W-1:0] r;
        unique case (sel)
            2'd0: r = {b, 24'h0};
            2'd1: r = {acc[31:24], b, 16'h0};
            2'd2: r = {acc[31:16], b, 8'h0};
            2'd3: r = {acc[31:8], b};
            default: r = '0;
        endcase
        return r;
    endfunction

    assign fill     = count_reg[5:0];
    assign widx     = fill[5:2];
    assign bsel     = fill[1:0];
    assign bit_len  = {count_reg, 3'b000};
    assign merged   = byte_merge(acc_reg, data_byte, bsel);
    assign pad_word = byte_merge(acc_reg, sha1s_pkg::PAD_BYTE, bsel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1s_pkg::ST_IDLE;
            count_reg <= '0;
            pidx_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            long_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pidx_reg  <= pidx_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            long_reg  <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        pidx_next    = pidx_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        fin_next     = fin_reg;
        long_next    = long_reg;
        ctrl         = '0;
        cmd_ready    = 1'b0;
        digest_valid = 1'b0;
        we           = 1'b0;
        waddr        = widx;
        wdata        = '0;
        base         = '0;

        unique case (state_reg)
            sha1s_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (command == sha1s_pkg::CMD_ABSORB)
                    begin
                        acc_next   = merged;
                        count_next = count_reg + sha1s_pkg::CountW'(1);
                        fin_next   = 1'b0;
                        if (bsel == 2'd3)
                        begin
                            we    = 1'b1;
                            wdata = merged;
                        end
                        if (fill == 6'd63)
                        begin
                            state_next = sha1s_pkg::ST_PRIME;
                        end
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        long_next  = (widx >= AW'(14));
                        state_next = sha1s_pkg::ST_PAD;
                    end
                end
            end

            sha1s_pkg::ST_PAD:
            begin
                we    = 1'b1;
                wdata = pad_word;
                if (widx == AW'(15))
                begin
                    state_next = sha1s_pkg::ST_PRIME;
                end
                else
                begin
                    pidx_next  = widx + AW'(1);
                    state_next = sha1s_pkg::ST_FILL;
                end
            end

            sha1s_pkg::ST_FILL:
            begin
                we        = 1'b1;
                waddr     = pidx_reg;
                pidx_next = pidx_reg + AW'(1);
                if (!long_reg && pidx_reg == AW'(14))
                begin
                    wdata = bit_len[63:32];
                end
                else if (!long_reg && pidx_reg == AW'(15))
                begin
                    wdata = bit_len[31:0];
                end
                if (pidx_reg == AW'(15))
                begin
                    state_next = sha1s_pkg::ST_PRIME;
                end
            end

            sha1s_pkg::ST_PRIME:
            begin
                ctrl.load  = 1'b1;
                rnd_next   = '0;
                state_next = sha1s_pkg::ST_ROUND;
            end

            sha1s_pkg::ST_ROUND:
            begin
                // reads for the next round go out now; a word written here is
                // next needed three rounds on, so no forwarding path
                ctrl.step = 1'b1;
                base      = rnd_reg[AW-1:0] + AW'(1);
                we        = (rnd_reg >= sha1s_pkg::RndW'(16));
                waddr     = rnd_reg[AW-1:0];
                wdata     = core_w;
                rnd_next  = rnd_reg + sha1s_pkg::RndW'(1);
                if (rnd_reg == sha1s_pkg::RndW'(sha1s_pkg::Rounds - 1))
                begin
                    state_next = sha1s_pkg::ST_ADD;
                end
            end

            sha1s_pkg::ST_ADD:
            begin
                ctrl.add = 1'b1;
                priority if (!fin_reg)
                begin
                    state_next = sha1s_pkg::ST_IDLE;
                end
                else if (long_reg)
                begin
                    // long tail: second block of zeros plus length
                    long_next  = 1'b0;
                    pidx_next  = '0;
                    state_next = sha1s_pkg::ST_FILL;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = sha1s_pkg::ST_OUT;
                end
            end

            sha1s_pkg::ST_OUT:
            begin
                digest_valid = 1'b1;
                if (digest_ready)
                begin
                    idx_next = idx_reg + sha1s_pkg::IdxW'(1);
                    if (idx_reg == sha1s_pkg::IdxW'(sha1s_pkg::NumWords - 1))
                    begin
                        ctrl.iv    = 1'b1;
                        count_next = '0;
                        fin_next   = 1'b0;
                        state_next = sha1s_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sha1s_pkg::ST_IDLE;
            end
        endcase
    end

    // window copies: A serves taps r-3 and r-8, B serves r-14 and r-16
    sha1s_wram u_wram_a (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (base - AW'(3)),
        .raddr1 (base - AW'(8)),
        .rdata0 (rd3),
        .rdata1 (rd8)
    );

    sha1s_wram u_wram_b (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (base - AW'(14)),
        .raddr1 (base),
        .rdata0 (rd14),
        .rdata1 (rd16)
    );

    sha1s_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .rnd        (rnd_reg),
        .w3         (rd3),
        .w8         (rd8),
        .w14        (rd14),
        .w16        (rd16),
        .word_sel   (idx_reg),
        .w          (core_w),
        .chain_word (digest_word)
    );

    assign word_index = idx_reg;
    assign last_word  = (idx_reg == sha1s_pkg::IdxW'(sha1s_pkg::NumWords - 1));

    a_no_cmd_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> !cmd_ready)
        else $error("command accepted while digest pending");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1s_pkg::ST_ROUND &&
         rnd_reg == sha1s_pkg::RndW'(sha1s_pkg::Rounds - 1))
        |=> state_reg == sha1s_pkg::ST_ADD)
        else $error("compression did not close after last round");

    a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && last_word)
        |=> (count_reg == '0 && state_reg == sha1s_pkg::ST_IDLE))
        else $error("count not cleared after digest");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> idx_reg <= sha1s_pkg::IdxW'(sha1s_pkg::NumWords - 1))
        else $error("digest word index out of range");

endmodule
